// ===== design/gnr_pkg.sv =====
package gnr_pkg;

  // Default geometry and step costs
  localparam int unsigned GRID_ROWS_DEF = 64;
  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned DIAG_COST_DEF = 14;
  localparam int unsigned SIDE_COST_DEF = 10;

  // Field widths
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned MAP_W      = 7;
  localparam int unsigned COST_W     = 16;
  localparam int unsigned PARENT_W   = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned PC_W       = 4;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Cell status codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_EXPAND = 2'd1,
    ACT_CLOSE  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Neighbor offset along one axis
  typedef enum logic [1:0] {
    OFF_ZERO  = 2'd0,
    OFF_PLUS  = 2'd1,
    OFF_MINUS = 2'd2
  } off_e;

  // Sequencer jump conditions
  typedef enum logic [1:0] {
    JC_NEXT = 2'd0,
    JC_END  = 2'd1,
    JC_OOM  = 2'd2
  } jc_e;

  // Microcode entry points
  localparam logic [PC_W-1:0] UA_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] UA_CLOSE = 4'd1;
  localparam logic [PC_W-1:0] UA_ACK   = 4'd2;
  localparam logic [PC_W-1:0] UA_EXP   = 4'd3;
  localparam logic [PC_W-1:0] UA_FLUSH = 4'd13;

  typedef struct packed {
    logic            rd_cur;
    logic            rd_nbr;
    off_e            dr;
    off_e            dc;
    logic            latch_g;
    logic            eval;
    logic            wr_load;
    logic            wr_close;
    logic            emit_ack;
    logic            flush;
    jc_e             jc;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   accept;
    uword_t uw;
  } ctrl_t;

  // Cost part of one cell
  typedef struct packed {
    logic [COST_W-1:0]   path;
    logic [COST_W-1:0]   total;
    logic [PARENT_W-1:0] parent;
  } cost_rec_t;

  // One result payload
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COST_W-1:0]  g;
    logic [COST_W-1:0]  h;
    logic [COST_W-1:0]  f;
  } res_t;

  // Control store: one word per step
  function automatic uword_t uc_rom(logic [PC_W-1:0] pc);
    uword_t w;
    w = uword_t'('0);
    unique case (pc)
      UA_LOAD: begin
        w.wr_load  = 1'b1;
        w.emit_ack = 1'b1;
        w.jc       = JC_END;
      end
      UA_CLOSE: begin
        w.wr_close = 1'b1;
        w.emit_ack = 1'b1;
        w.jc       = JC_END;
      end
      UA_ACK: begin
        w.emit_ack = 1'b1;
        w.jc       = JC_END;
      end
      UA_EXP: begin
        w.rd_cur = 1'b1;
        w.jc     = JC_OOM;
        w.target = UA_ACK;
      end
      4'd4: begin
        w.rd_nbr  = 1'b1;
        w.dr      = OFF_MINUS;
        w.dc      = OFF_MINUS;
        w.latch_g = 1'b1;
      end
      4'd5: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_MINUS;
        w.dc     = OFF_ZERO;
        w.eval   = 1'b1;
      end
      4'd6: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_MINUS;
        w.dc     = OFF_PLUS;
        w.eval   = 1'b1;
      end
      4'd7: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_ZERO;
        w.dc     = OFF_MINUS;
        w.eval   = 1'b1;
      end
      4'd8: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_ZERO;
        w.dc     = OFF_PLUS;
        w.eval   = 1'b1;
      end
      4'd9: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_PLUS;
        w.dc     = OFF_MINUS;
        w.eval   = 1'b1;
      end
      4'd10: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_PLUS;
        w.dc     = OFF_ZERO;
        w.eval   = 1'b1;
      end
      4'd11: begin
        w.rd_nbr = 1'b1;
        w.dr     = OFF_PLUS;
        w.dc     = OFF_PLUS;
        w.eval   = 1'b1;
      end
      4'd12: begin
        w.eval = 1'b1;
      end
      UA_FLUSH: begin
        w.flush = 1'b1;
        w.jc    = JC_END;
      end
      default: begin
        w.jc = JC_END;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/grid_astar_neighbor_relax_unit.sv =====
// Channel  | Signals                                             | Direction
// ---------+-----------------------------------------------------+----------
// request  | start, busy, action_i, cell_row_i, cell_col_i,      | in
//          | blocked_i                                           |
// result   | res_valid_o, nbr_row_o, nbr_col_o, path_cost_o,     | out
//          | heur_cost_o, total_cost_o, updated_o, last_o        |
// config   | cfg_we_i, cfg_idx_i, cfg_data_i                     | in
//
// Load, close and unknown requests take one step; busy is low again in that step.
// Expand runs 11 steps (2 when the current cell is off the map): one read of the
// current cell, then the eight neighbor reads through the single table read port,
// one final relax step and one flush step. An acknowledgement leaves in the cycle after
// its step; an updated neighbor is held until the next update or the flush step and
// leaves in the cycle after that step.
// Reset clears control and configuration; the cell table is not cleared and every
// cell must be loaded before it is read. The result strobe cannot be stalled.
module grid_astar_neighbor_relax_unit import gnr_pkg::*; #(
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned DIAG_COST = DIAG_COST_DEF,
  parameter int unsigned SIDE_COST = SIDE_COST_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [COORD_W-1:0]    cell_row_i,
  input  logic [COORD_W-1:0]    cell_col_i,
  input  logic                  blocked_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  output logic [COORD_W-1:0]    nbr_row_o,
  output logic [COORD_W-1:0]    nbr_col_o,
  output logic [COST_W-1:0]     path_cost_o,
  output logic [COST_W-1:0]     heur_cost_o,
  output logic [COST_W-1:0]     total_cost_o,
  output logic                  updated_o,
  output logic                  last_o
);

  ctrl_t ctrl;
  logic  cur_oom;
  res_t  res;

  // Microcode sequencer
  gnr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .action_i  (action_i),
    .cur_oom_i (cur_oom),
    .busy      (busy),
    .ctrl_o    (ctrl)
  );

  // Datapath with cell table
  gnr_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .DIAG_COST (DIAG_COST),
    .SIDE_COST (SIDE_COST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .blocked_i   (blocked_i),
    .ctrl_i      (ctrl),
    .cur_oom_o   (cur_oom),
    .res_valid_o (res_valid_o),
    .res_o       (res),
    .updated_o   (updated_o),
    .last_o      (last_o)
  );

  assign nbr_row_o    = res.row;
  assign nbr_col_o    = res.col;
  assign path_cost_o  = res.g;
  assign heur_cost_o  = res.h;
  assign total_cost_o = res.f;

endmodule

// ===== design/gnr_ram.sv =====
module gnr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gnr_seq.sv =====
module gnr_seq import gnr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] action_i,
  input  logic       cur_oom_i,
  output logic       busy,
  output ctrl_t      ctrl_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [PC_W-1:0] entry;
  logic            accept;
  uword_t          uw;

  // Current control word, no-op while idle
  always_comb begin
    uw = busy_q ? uc_rom(pc_q) : uword_t'('0);
  end

  // Free on the final step of a program
  assign busy   = busy_q & (uw.jc != JC_END);
  assign accept = start & ~busy;

  // Program entry per request type
  always_comb begin
    unique case (action_e'(action_i))
      ACT_LOAD:   entry = UA_LOAD;
      ACT_EXPAND: entry = UA_EXP;
      ACT_CLOSE:  entry = UA_CLOSE;
      default:    entry = UA_ACK;
    endcase
  end

  // Step counter and jumps
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (busy_q) begin
      unique case (uw.jc)
        JC_NEXT: pc_d = pc_q + 1'b1;
        JC_OOM:  pc_d = cur_oom_i ? uw.target : pc_q + 1'b1;
        default: busy_d = 1'b0;
      endcase
    end
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= UA_LOAD;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o.accept = accept;
  assign ctrl_o.uw     = uw;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= UA_FLUSH)
    else $error("step counter beyond program");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted request did not start a program");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.jc == JC_END && !accept) |=> !busy_q)
    else $error("sequencer did not stop at end step");

endmodule

// ===== design/gnr_dp.sv =====
module gnr_dp import gnr_pkg::*; #(
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned DIAG_COST = DIAG_COST_DEF,
  parameter int unsigned SIDE_COST = SIDE_COST_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [COORD_W-1:0]    cell_row_i,
  input  logic [COORD_W-1:0]    cell_col_i,
  input  logic                  blocked_i,
  input  ctrl_t                 ctrl_i,
  output logic                  cur_oom_o,
  output logic                  res_valid_o,
  output res_t                  res_o,
  output logic                  updated_o,
  output logic                  last_o
);

  localparam int unsigned CELLS  = GRID_ROWS * GRID_COLS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned LIM_W  = 9;
  localparam int unsigned CW1    = COST_W + 1;
  localparam int unsigned COST_RW = $bits(cost_rec_t);

  uword_t uw;
  assign uw = ctrl_i.uw;

  // Configuration registers
  logic [MAP_W-1:0]   map_rows_q, map_cols_q;
  logic [COORD_W-1:0] start_row_q, start_col_q, goal_row_q, goal_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q  <= MAP_W'(64);
      map_cols_q  <= MAP_W'(64);
      start_row_q <= '0;
      start_col_q <= '0;
      goal_row_q  <= '0;
      goal_col_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_ROWS:  map_rows_q  <= cfg_data_i;
        REG_MAP_COLS:  map_cols_q  <= cfg_data_i;
        REG_START_ROW: start_row_q <= cfg_data_i[COORD_W-1:0];
        REG_START_COL: start_col_q <= cfg_data_i[COORD_W-1:0];
        REG_GOAL_ROW:  goal_row_q  <= cfg_data_i[COORD_W-1:0];
        REG_GOAL_COL:  goal_col_q  <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Request registers
  logic [COORD_W-1:0] row_q, col_q;
  logic               blk_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      row_q <= cell_row_i;
      col_q <= cell_col_i;
      blk_q <= blocked_i;
    end
  end

  // Map bounds, clipped to the table
  logic [MAP_W-1:0] rows_lim, cols_lim;
  logic             in_table;
  logic [ADDR_W-1:0] cur_addr;

  assign rows_lim = ({{(LIM_W-MAP_W){1'b0}}, map_rows_q} > LIM_W'(GRID_ROWS)) ?
                    MAP_W'(GRID_ROWS) : map_rows_q;
  assign cols_lim = ({{(LIM_W-MAP_W){1'b0}}, map_cols_q} > LIM_W'(GRID_COLS)) ?
                    MAP_W'(GRID_COLS) : map_cols_q;
  assign cur_oom_o = !(({1'b0, row_q} < rows_lim) && ({1'b0, col_q} < cols_lim));
  assign in_table  = (LIM_W'(row_q) < LIM_W'(GRID_ROWS)) &&
                     (LIM_W'(col_q) < LIM_W'(GRID_COLS));
  assign cur_addr  = ADDR_W'(32'(row_q) * 32'(GRID_COLS) + 32'(col_q));

  // Neighbor coordinates for this step
  logic [MAP_W-1:0]  nr, nc;
  logic              edge_ok, nbr_ok;
  logic [ADDR_W-1:0] nbr_addr;

  always_comb begin
    edge_ok = 1'b1;
    unique case (uw.dr)
      OFF_MINUS: begin
        nr      = {1'b0, row_q} - 1'b1;
        edge_ok = (row_q != '0);
      end
      OFF_PLUS: nr = {1'b0, row_q} + 1'b1;
      default:  nr = {1'b0, row_q};
    endcase
    unique case (uw.dc)
      OFF_MINUS: begin
        nc      = {1'b0, col_q} - 1'b1;
        edge_ok = edge_ok & (col_q != '0);
      end
      OFF_PLUS: nc = {1'b0, col_q} + 1'b1;
      default:  nc = {1'b0, col_q};
    endcase
  end

  assign nbr_ok   = edge_ok && (nr < rows_lim) && (nc < cols_lim) &&
                    !((nr == {1'b0, start_row_q}) && (nc == {1'b0, start_col_q}));
  assign nbr_addr = ADDR_W'(32'(nr) * 32'(GRID_COLS) + 32'(nc));

  // Octile heuristic to the goal
  logic [MAP_W-1:0]  d_row, d_col, d_lo, d_hi;
  logic [CW1-1:0]    h_full;
  logic [COST_W-1:0] h_sat;

  assign d_row  = (nr > {1'b0, goal_row_q}) ? nr - {1'b0, goal_row_q} : {1'b0, goal_row_q} - nr;
  assign d_col  = (nc > {1'b0, goal_col_q}) ? nc - {1'b0, goal_col_q} : {1'b0, goal_col_q} - nc;
  assign d_lo   = (d_row < d_col) ? d_row : d_col;
  assign d_hi   = (d_row < d_col) ? d_col : d_row;
  assign h_full = CW1'(DIAG_COST) * CW1'(d_lo) + CW1'(SIDE_COST) * CW1'(d_hi - d_lo);
  assign h_sat  = h_full[COST_W] ? COST_MAX : h_full[COST_W-1:0];

  // Neighbor stage, lines up with the read data
  logic [COORD_W-1:0] nbr_row_q, nbr_col_q;
  logic [COST_W-1:0]  nbr_h_q;
  logic               nbr_diag_q, nbr_ok_q;
  logic [ADDR_W-1:0]  nbr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_ok_q <= 1'b0;
    end else if (uw.rd_nbr) begin
      nbr_ok_q <= nbr_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.rd_nbr) begin
      nbr_row_q  <= nr[COORD_W-1:0];
      nbr_col_q  <= nc[COORD_W-1:0];
      nbr_h_q    <= h_sat;
      nbr_diag_q <= (uw.dr != OFF_ZERO) && (uw.dc != OFF_ZERO);
      nbr_addr_q <= nbr_addr;
    end
  end

  // Cell table: blocked flag, status, costs and parent
  logic              rd_blk;
  logic [1:0]        rd_st;
  cost_rec_t         rd_cost;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we_blk, we_st, we_cost;
  logic [1:0]        wd_st;
  cost_rec_t         wd_cost;

  assign raddr = uw.rd_cur ? cur_addr : nbr_addr;

  gnr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (we_blk),
    .waddr_i (waddr),
    .wdata_i (blk_q),
    .raddr_i (raddr),
    .rdata_o (rd_blk)
  );

  gnr_ram #(.WIDTH(2), .DEPTH(CELLS)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (we_st),
    .waddr_i (waddr),
    .wdata_i (wd_st),
    .raddr_i (raddr),
    .rdata_o (rd_st)
  );

  gnr_ram #(.WIDTH(COST_RW), .DEPTH(CELLS)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (we_cost),
    .waddr_i (waddr),
    .wdata_i (wd_cost),
    .raddr_i (raddr),
    .rdata_o (rd_cost)
  );

  // Cost of the current cell
  logic [COST_W-1:0] cur_g_q;

  always_ff @(posedge clk_i) begin
    if (uw.latch_g) begin
      cur_g_q <= rd_cost.path;
    end
  end

  // Relaxation of one neighbor
  logic [CW1-1:0]    g_full, f_full;
  logic [COST_W-1:0] g_sat, f_sat;
  logic              upd;

  assign g_full = {1'b0, cur_g_q} + (nbr_diag_q ? CW1'(DIAG_COST) : CW1'(SIDE_COST));
  assign g_sat  = g_full[COST_W] ? COST_MAX : g_full[COST_W-1:0];
  assign f_full = {1'b0, g_sat} + {1'b0, nbr_h_q};
  assign f_sat  = f_full[COST_W] ? COST_MAX : f_full[COST_W-1:0];
  assign upd    = uw.eval && nbr_ok_q && !rd_blk && (rd_st != ST_CLOSED) &&
                  ((rd_st == ST_NONE) || (rd_cost.total > f_sat));

  // Table writes
  assign we_blk  = uw.wr_load && in_table;
  assign we_st   = ((uw.wr_load || uw.wr_close) && in_table) || upd;
  assign we_cost = (uw.wr_load && in_table) || upd;
  assign waddr   = upd ? nbr_addr_q : cur_addr;
  assign wd_st   = upd ? ST_OPEN : (uw.wr_close ? ST_CLOSED : ST_NONE);

  always_comb begin
    wd_cost = cost_rec_t'('0);
    if (upd) begin
      wd_cost.path   = g_sat;
      wd_cost.total  = f_sat;
      wd_cost.parent = {row_q, col_q};
    end
  end

  // One result held back so the final one can carry last
  res_t pend_q;
  logic pend_valid_q;
  res_t new_res;

  assign new_res = '{row: nbr_row_q, col: nbr_col_q, g: g_sat, h: nbr_h_q, f: f_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (upd) begin
      pend_valid_q <= 1'b1;
    end else if (uw.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      pend_q <= new_res;
    end
  end

  // Result register
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;
  logic updated_q, updated_d, last_q, last_d;

  always_comb begin
    res_valid_d = 1'b0;
    res_d       = res_q;
    updated_d   = updated_q;
    last_d      = last_q;
    priority if (uw.emit_ack || (uw.flush && !pend_valid_q)) begin
      res_valid_d = 1'b1;
      res_d       = res_t'('0);
      updated_d   = 1'b0;
      last_d      = 1'b1;
    end else if (uw.flush) begin
      res_valid_d = 1'b1;
      res_d       = pend_q;
      updated_d   = 1'b1;
      last_d      = 1'b1;
    end else if (upd && pend_valid_q) begin
      res_valid_d = 1'b1;
      res_d       = pend_q;
      updated_d   = 1'b1;
      last_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    updated_q <= updated_d;
    last_q    <= last_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign updated_o   = updated_q;
  assign last_o      = last_q;

  a_flush_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.flush |=> res_valid_q && last_q)
    else $error("flush step gave no final result");

  a_ack_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.emit_ack |=> res_valid_q && last_q && !updated_q)
    else $error("acknowledge step gave wrong result");

  a_mid_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !last_q) |-> (pend_valid_q && updated_q))
    else $error("non-final result without a held neighbor");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gnr_pkg::*;

  localparam int ROWS_T  = GRID_ROWS_DEF;
  localparam int COLS_T  = GRID_COLS_DEF;
  localparam int N_CELLS = ROWS_T * COLS_T;

  // One neighbor update (or acknowledgement) as it leaves the block
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COST_W-1:0]  g;
    logic [COST_W-1:0]  h;
    logic [COST_W-1:0]  f;
    logic               upd;
    logic               last;
  } nbr_update_t;

  // Shadow of the cell table and registers, plus the pending updates
  class relax_scoreboard;
    bit          blk_q    [N_CELLS];
    bit [1:0]    status_q [N_CELLS];
    int          g_q      [N_CELLS];
    int          f_q      [N_CELLS];
    int          parent_q [N_CELLS];
    int          map_rows, map_cols, start_row, start_col, goal_row, goal_col;
    nbr_update_t expected_updates [$];
    int          opened_cells [$];
    int          mismatches;

    function new();
      map_rows   = 64;
      map_cols   = 64;
      start_row  = 0;
      start_col  = 0;
      goal_row   = 0;
      goal_col   = 0;
      mismatches = 0;
    endfunction

    function int used_rows();
      return (map_rows < ROWS_T) ? map_rows : ROWS_T;
    endfunction

    function int used_cols();
      return (map_cols < COLS_T) ? map_cols : COLS_T;
    endfunction

    function int sat16(int v);
      return (v > COST_MAX) ? COST_MAX : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAP_ROWS:  map_rows  = data;
        REG_MAP_COLS:  map_cols  = data;
        REG_START_ROW: start_row = data[COORD_W-1:0];
        REG_START_COL: start_col = data[COORD_W-1:0];
        REG_GOAL_ROW:  goal_row  = data[COORD_W-1:0];
        REG_GOAL_COL:  goal_col  = data[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the updates it must produce
    function void note_request(action_e act, int row, int col, bit blk);
      int rows, cols, cur_k, nbr_k, nr, nc, cur_g, step, g, h, f, dr_a, dc_a, lo, hi, n_upd;
      nbr_update_t u;
      rows  = used_rows();
      cols  = used_cols();
      cur_k = row * COLS_T + col;
      n_upd = 0;
      if (act == ACT_LOAD) begin
        blk_q[cur_k]    = blk;
        status_q[cur_k] = ST_NONE;
        g_q[cur_k]      = 0;
        f_q[cur_k]      = 0;
        parent_q[cur_k] = 0;
      end else if (act == ACT_CLOSE) begin
        status_q[cur_k] = ST_CLOSED;
      end else if (act == ACT_EXPAND && row < rows && col < cols) begin
        cur_g = g_q[cur_k];
        // row offset outer, column offset inner, center skipped
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = row + dr;
            nc = col + dc;
            if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= rows || nc >= cols) begin
              continue;
            end
            nbr_k = nr * COLS_T + nc;
            if (blk_q[nbr_k] || status_q[nbr_k] == ST_CLOSED) begin
              continue;
            end
            if (nr == start_row && nc == start_col) begin
              continue;
            end
            step = (dr != 0 && dc != 0) ? DIAG_COST_DEF : SIDE_COST_DEF;
            g    = sat16(cur_g + step);
            // octile distance to the goal
            dr_a = (nr > goal_row) ? nr - goal_row : goal_row - nr;
            dc_a = (nc > goal_col) ? nc - goal_col : goal_col - nc;
            lo   = (dr_a < dc_a) ? dr_a : dc_a;
            hi   = (dr_a < dc_a) ? dc_a : dr_a;
            h    = sat16(DIAG_COST_DEF * lo + SIDE_COST_DEF * (hi - lo));
            f    = sat16(g + h);
            if (status_q[nbr_k] != ST_NONE && !(f_q[nbr_k] > f)) begin
              continue;
            end
            g_q[nbr_k]      = g;
            f_q[nbr_k]      = f;
            parent_q[nbr_k] = row * 64 + col;
            status_q[nbr_k] = ST_OPEN;
            u     = '0;
            u.row = COORD_W'(nr);
            u.col = COORD_W'(nc);
            u.g   = COST_W'(g);
            u.h   = COST_W'(h);
            u.f   = COST_W'(f);
            u.upd = 1'b1;
            expected_updates.push_back(u);
            opened_cells.push_back(nbr_k);
            if (opened_cells.size() > 48) begin
              void'(opened_cells.pop_front());
            end
            n_upd++;
          end
        end
      end
      // plain acknowledgement when nothing was updated
      if (n_upd == 0) begin
        u      = '0;
        u.last = 1'b1;
        expected_updates.push_back(u);
      end else begin
        expected_updates[expected_updates.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(nbr_update_t got);
      nbr_update_t want;
      bit bad;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result row %0d col %0d g %0d h %0d f %0d upd %0b last %0b",
                   $time, got.row, got.col, got.g, got.h, got.f, got.upd, got.last);
        end
        return;
      end
      want = expected_updates.pop_front();
      bad  = (got.row !== want.row) || (got.col !== want.col) || (got.g !== want.g) ||
             (got.h !== want.h) || (got.f !== want.f) || (got.upd !== want.upd) ||
             (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: wrong result, exp row %0d col %0d g %0d h %0d f %0d upd %0b last %0b",
                   $time, want.row, want.col, want.g, want.h, want.f, want.upd, want.last);
          $display("%0t:               got row %0d col %0d g %0d h %0d f %0d upd %0b last %0b",
                   $time, got.row, got.col, got.g, got.h, got.f, got.upd, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            action_i;
  logic [COORD_W-1:0]    cell_row_i;
  logic [COORD_W-1:0]    cell_col_i;
  logic                  blocked_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  res_valid_o;
  logic [COORD_W-1:0]    nbr_row_o;
  logic [COORD_W-1:0]    nbr_col_o;
  logic [COST_W-1:0]     path_cost_o;
  logic [COST_W-1:0]     heur_cost_o;
  logic [COST_W-1:0]     total_cost_o;
  logic                  updated_o;
  logic                  last_o;

  relax_scoreboard sb = new();
  bit              written [N_CELLS];
  bit              no_gaps;
  int              n_sent;

  always #5 clk_i = ~clk_i;

  grid_astar_neighbor_relax_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .blocked_i    (blocked_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (res_valid_o),
    .nbr_row_o    (nbr_row_o),
    .nbr_col_o    (nbr_col_o),
    .path_cost_o  (path_cost_o),
    .heur_cost_o  (heur_cost_o),
    .total_cost_o (total_cost_o),
    .updated_o    (updated_o),
    .last_o       (last_o)
  );

  // Result monitor: the strobe cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) begin
      sb.check_result('{row: nbr_row_o, col: nbr_col_o, g: path_cost_o, h: heur_cost_o,
                        f: total_cost_o, upd: updated_o, last: last_o});
    end
  end

  // Issue one request after a random gap; start stays high on return
  task automatic send_req(action_e act, int row, int col, bit blk);
    int gap;
    if ($urandom_range(0, 11) == 0) begin
      no_gaps = !no_gaps;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    cell_row_i <= COORD_W'(row);
    cell_col_i <= COORD_W'(col);
    blocked_i  <= blk;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(act, row, col, blk);
    if (act == ACT_LOAD) begin
      written[row * COLS_T + col] = 1'b1;
    end
    n_sent++;
  endtask

  // Stop sending and wait until every pending update has come out
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_updates.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic apply_config(int rows, int cols, int sr, int sc, int gr, int gc);
    logic [CFG_DATA_W-1:0] vals [6];
    logic [CFG_IDX_W-1:0]  regs [6];
    vals = '{CFG_DATA_W'(rows), CFG_DATA_W'(cols), CFG_DATA_W'(sr), CFG_DATA_W'(sc),
             CFG_DATA_W'(gr), CFG_DATA_W'(gc)};
    regs = '{REG_MAP_ROWS, REG_MAP_COLS, REG_START_ROW, REG_START_COL, REG_GOAL_ROW,
             REG_GOAL_COL};
    drain();
    foreach (vals[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load the cell and, when it is on the map, its map neighbors, each only if not yet loaded
  task automatic prepare_cell(int row, int col);
    int rows, cols;
    rows = sb.used_rows();
    cols = sb.used_cols();
    for (int r = row - 1; r <= row + 1; r++) begin
      for (int c = col - 1; c <= col + 1; c++) begin
        if ((r == row && c == col) ||
            (row < rows && col < cols && r >= 0 && c >= 0 && r < rows && c < cols)) begin
          if (!written[r * COLS_T + c]) begin
            send_req(ACT_LOAD, r, c, $urandom_range(0, 4) == 0);
          end
        end
      end
    end
  endtask

  task automatic random_item();
    int rows, cols, pick, row, col, k;
    rows = sb.used_rows();
    cols = sb.used_cols();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // expand: mostly from recently opened cells, some off the map
      if (pick >= 50 && rows < ROWS_T) begin
        row = $urandom_range(rows, ROWS_T - 1);
        col = $urandom_range(0, COLS_T - 1);
      end else if (pick >= 50 && cols < COLS_T) begin
        row = $urandom_range(0, ROWS_T - 1);
        col = $urandom_range(cols, COLS_T - 1);
      end else if (rows == 0 || cols == 0) begin
        row = $urandom_range(0, ROWS_T - 1);
        col = $urandom_range(0, COLS_T - 1);
      end else if (sb.opened_cells.size() > 0 && $urandom_range(0, 4) < 3) begin
        k   = sb.opened_cells[$urandom_range(0, sb.opened_cells.size() - 1)];
        row = k / COLS_T;
        col = k % COLS_T;
        if (row >= rows || col >= cols) begin
          row = $urandom_range(0, rows - 1);
          col = $urandom_range(0, cols - 1);
        end
      end else begin
        row = $urandom_range(0, rows - 1);
        col = $urandom_range(0, cols - 1);
      end
      prepare_cell(row, col);
      send_req(ACT_EXPAND, row, col, 1'($urandom_range(0, 1)));
    end else if (pick < 78) begin
      // load, on the map half the time
      if (rows > 0 && cols > 0 && $urandom_range(0, 1)) begin
        row = $urandom_range(0, rows - 1);
        col = $urandom_range(0, cols - 1);
      end else begin
        row = $urandom_range(0, ROWS_T - 1);
        col = $urandom_range(0, COLS_T - 1);
      end
      send_req(ACT_LOAD, row, col, $urandom_range(0, 3) == 0);
    end else if (pick < 93) begin
      // close an open cell or any cell, loading it first if needed
      if (sb.opened_cells.size() > 0 && $urandom_range(0, 1)) begin
        k   = sb.opened_cells[$urandom_range(0, sb.opened_cells.size() - 1)];
        row = k / COLS_T;
        col = k % COLS_T;
      end else begin
        row = $urandom_range(0, ROWS_T - 1);
        col = $urandom_range(0, COLS_T - 1);
      end
      if (!written[row * COLS_T + col]) begin
        send_req(ACT_LOAD, row, col, 1'b0);
      end
      send_req(ACT_CLOSE, row, col, 1'($urandom_range(0, 1)));
    end else begin
      send_req(ACT_NOP, $urandom_range(0, ROWS_T - 1), $urandom_range(0, COLS_T - 1),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int rows, int cols, int sr, int sc, int gr, int gc, int n_items);
    int stop_at, pause_at;
    bit paused;
    apply_config(rows, cols, sr, sc, gr, gc);
    stop_at  = n_sent + n_items;
    pause_at = n_sent + n_items / 2;
    paused   = 1'b0;
    while (n_sent < stop_at) begin
      random_item();
      // hold off halfway until the block has caught up
      if (!paused && n_sent >= pause_at) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // Hang guard
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    action_i   <= ACT_LOAD;
    cell_row_i <= '0;
    cell_col_i <= '0;
    blocked_i  <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_MAP_ROWS;
    cfg_data_i <= '0;
    no_gaps    = 1'b0;
    n_sent     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner around the start cell, goal in the far corner
    apply_config(64, 64, 0, 0, 63, 63);
    send_req(ACT_LOAD, 0, 0, 1'b0);
    send_req(ACT_LOAD, 0, 1, 1'b0);
    send_req(ACT_LOAD, 1, 0, 1'b1);
    send_req(ACT_LOAD, 1, 1, 1'b0);
    send_req(ACT_EXPAND, 0, 0, 1'b1);
    send_req(ACT_CLOSE, 1, 1, 1'b0);
    send_req(ACT_LOAD, 0, 2, 1'b0);
    send_req(ACT_LOAD, 1, 2, 1'b0);
    // start, blocked and closed neighbors are all skipped here
    send_req(ACT_EXPAND, 0, 1, 1'b0);
    // nothing improves: acknowledgement only
    send_req(ACT_EXPAND, 0, 0, 1'b0);
    // a fresh cell next to open ones improves them
    prepare_cell(2, 2);
    send_req(ACT_EXPAND, 2, 2, 1'b1);
    send_req(ACT_NOP, 63, 63, 1'b1);
    send_req(ACT_LOAD, 63, 63, 1'b1);
    prepare_cell(63, 63);
    send_req(ACT_EXPAND, 63, 63, 1'b0);

    // Random phases over several map shapes
    run_phase(8, 8, 3, 3, 7, 0, 35);
    run_phase(127, 127, 127, 63, 0, 63, 30);
    run_phase(1, 64, 0, 10, 0, 63, 25);
    run_phase(0, 5, 0, 0, 0, 0, 15);
    run_phase(5, 1, 4, 0, 0, 0, 20);
    run_phase(12, 10, $urandom_range(0, 11), $urandom_range(0, 9), $urandom_range(0, 63),
              $urandom_range(0, 63), 45);
    run_phase(6, 6, 0, 0, 5, 5, 30);

    drain();
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
